// ===== rtl/pcoq_pkg.sv =====
// Shared types and constants for the pending commit order queue.
// No dependencies; every other file in rtl/ except pcoq_ram uses this package.
package pcoq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int CONN_W  = 32;
	localparam int OP_W    = 32;
	localparam int TOKEN_W = 64;

	typedef enum logic [1:0] {
		CMD_QUEUE    = 2'd0,
		CMD_COMMIT   = 2'd1,
		CMD_REWIND   = 2'd2,
		CMD_GRADUATE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPEND,
		ST_MATCH,
		ST_UPDATE,
		ST_SHIFT,
		ST_PREFIX,
		ST_DONE
	} state_t;

	// one stored queue entry
	typedef struct packed {
		logic [CONN_W-1:0]  conn;
		logic [OP_W-1:0]    op;
		logic [TOKEN_W-1:0] token;
		logic               committed;
	} entry_t;

	// result word handed from the sequencer to the output register
	typedef struct packed {
		logic               found;
		logic               max_valid;
		logic [TOKEN_W-1:0] max_csn;
		logic               queue_full;
	} res_t;

endpackage

// ===== rtl/pcoq_cmd_if.sv =====
// Command channel: valid/ready handshake with the command word payload.
// Depends on pcoq_pkg for field widths.
interface pcoq_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   cmd;
	logic [pcoq_pkg::CONN_W-1:0]  conn_id;
	logic [pcoq_pkg::OP_W-1:0]    op_id;
	logic [pcoq_pkg::TOKEN_W-1:0] csn_token;

	modport source (output valid, cmd, conn_id, op_id, csn_token, input ready);
	modport sink   (input valid, cmd, conn_id, op_id, csn_token, output ready);
endinterface

// ===== rtl/pcoq_rsp_if.sv =====
// Response channel: valid/ready handshake with the result word payload.
// Depends on pcoq_pkg for field widths.
interface pcoq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic                         max_valid;
	logic [pcoq_pkg::TOKEN_W-1:0] max_csn;
	logic                         queue_full;

	modport source (output valid, found, max_valid, max_csn, queue_full, input ready);
	modport sink   (input valid, found, max_valid, max_csn, queue_full, output ready);
endinterface

// ===== rtl/pcoq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
module pcoq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/pcoq_seq.sv =====
// Sequencer: walks the entry RAM one address per cycle for the match,
// shift and committed-prefix passes. Depends on pcoq_pkg and pcoq_cmd_if.
module pcoq_seq #(
	parameter int QUEUE_DEPTH = pcoq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	pcoq_cmd_if.sink                 cmd_ch,
	// entry RAM
	output logic                     ram_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
	output pcoq_pkg::entry_t         ram_wdata,
	output logic                     ram_re,
	output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
	input  pcoq_pkg::entry_t         ram_rdata,
	// result to output register
	output logic                     res_valid,
	input  logic                     res_ready,
	output pcoq_pkg::res_t           res
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	pcoq_pkg::state_t state_q, state_d;

	// control
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	logic          rd_vld_s1;
	logic [CW-1:0] rd_idx_s1;

	// payload
	pcoq_pkg::cmd_t                 cmd_q;
	logic [pcoq_pkg::CONN_W-1:0]    conn_q;
	logic [pcoq_pkg::OP_W-1:0]      op_q;
	logic [pcoq_pkg::TOKEN_W-1:0]   token_q;
	logic [CW-1:0]                  hit_idx_q;
	pcoq_pkg::entry_t               hit_ent_q;
	logic                           found_q;
	logic                           max_valid_q;
	logic [pcoq_pkg::TOKEN_W-1:0]   max_csn_q;
	logic                           full_q;

	logic          accept;
	logic          more;
	logic          hit;
	logic          pass_end;
	logic          restart;
	logic [CW-1:0] restart_at;
	logic [CW-1:0] shift_dst;
	logic          is_full;

	assign accept    = cmd_ch.valid && cmd_ch.ready;
	assign more      = scan_q < count_q;
	assign hit       = rd_vld_s1 && ram_rdata.conn == conn_q && ram_rdata.op == op_q;
	assign pass_end  = !more && !rd_vld_s1;
	assign shift_dst = rd_idx_s1 - CW'(1);
	assign is_full   = count_q == CW'(QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcoq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd_ch.ready = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = scan_q[AW-1:0];
		ram_wdata    = hit_ent_q;
		ram_re       = 1'b0;
		ram_raddr    = scan_q[AW-1:0];
		res_valid    = 1'b0;
		restart      = 1'b0;
		restart_at   = '0;
		case (state_q)
			pcoq_pkg::ST_IDLE: begin
				cmd_ch.ready = 1'b1;
				// ready is high here, so valid alone means the word is taken
				if (cmd_ch.valid) begin
					restart = 1'b1;
					if (pcoq_pkg::cmd_t'(cmd_ch.cmd) == pcoq_pkg::CMD_QUEUE) begin
						state_d = pcoq_pkg::ST_APPEND;
					end else begin
						state_d = pcoq_pkg::ST_MATCH;
					end
				end
			end
			pcoq_pkg::ST_APPEND: begin
				ram_we    = !is_full;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = '{conn: conn_q, op: op_q, token: token_q, committed: 1'b0};
				state_d   = pcoq_pkg::ST_DONE;
			end
			pcoq_pkg::ST_MATCH: begin
				ram_re = more && !hit;
				if (hit) begin
					if (cmd_q == pcoq_pkg::CMD_GRADUATE) begin
						restart    = 1'b1;
						restart_at = rd_idx_s1 + CW'(1);
						state_d    = pcoq_pkg::ST_SHIFT;
					end else begin
						state_d = pcoq_pkg::ST_UPDATE;
					end
				end else if (pass_end) begin
					if (cmd_q == pcoq_pkg::CMD_COMMIT) begin
						restart = 1'b1;
						state_d = pcoq_pkg::ST_PREFIX;
					end else begin
						state_d = pcoq_pkg::ST_DONE;
					end
				end
			end
			pcoq_pkg::ST_UPDATE: begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q[AW-1:0];
				ram_wdata = hit_ent_q;
				ram_wdata.committed = cmd_q == pcoq_pkg::CMD_COMMIT;
				if (cmd_q == pcoq_pkg::CMD_COMMIT) begin
					restart = 1'b1;
					state_d = pcoq_pkg::ST_PREFIX;
				end else begin
					state_d = pcoq_pkg::ST_DONE;
				end
			end
			pcoq_pkg::ST_SHIFT: begin
				ram_re    = more;
				ram_we    = rd_vld_s1;
				ram_waddr = shift_dst[AW-1:0];
				ram_wdata = ram_rdata;
				if (pass_end) begin
					state_d = pcoq_pkg::ST_DONE;
				end
			end
			pcoq_pkg::ST_PREFIX: begin
				ram_re = more && !(rd_vld_s1 && !ram_rdata.committed);
				if (pass_end || (rd_vld_s1 && !ram_rdata.committed)) begin
					state_d = pcoq_pkg::ST_DONE;
				end
			end
			pcoq_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = pcoq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pcoq_pkg::ST_IDLE;
			end
		endcase
	end

	// scan pointer, read-in-flight flag and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (restart) begin
				scan_q    <= restart_at;
				rd_vld_s1 <= 1'b0;
			end else begin
				scan_q    <= scan_q + CW'(ram_re);
				rd_vld_s1 <= ram_re;
			end
			if (state_q == pcoq_pkg::ST_APPEND && !is_full) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == pcoq_pkg::ST_SHIFT && pass_end) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (accept) begin
			cmd_q       <= pcoq_pkg::cmd_t'(cmd_ch.cmd);
			conn_q      <= cmd_ch.conn_id;
			op_q        <= cmd_ch.op_id;
			token_q     <= cmd_ch.csn_token;
			found_q     <= 1'b0;
			max_valid_q <= 1'b0;
			max_csn_q   <= '0;
			full_q      <= 1'b0;
		end
		if (state_q == pcoq_pkg::ST_APPEND) begin
			full_q <= is_full;
		end
		if (state_q == pcoq_pkg::ST_MATCH && hit) begin
			found_q   <= 1'b1;
			hit_idx_q <= rd_idx_s1;
			hit_ent_q <= ram_rdata;
		end
		if (state_q == pcoq_pkg::ST_PREFIX && rd_vld_s1 && ram_rdata.committed) begin
			max_valid_q <= 1'b1;
			max_csn_q   <= ram_rdata.token;
		end
	end

	assign res = '{found: found_q, max_valid: max_valid_q, max_csn: max_csn_q,
		queue_full: full_q};

endmodule

// ===== rtl/pending_commit_order_queue_top.sv =====
// Top level of the pending commit order queue.
// Depends on pcoq_pkg, pcoq_cmd_if, pcoq_rsp_if, pcoq_ram and pcoq_seq.
//
// Usage
//   cmd_ch carries one command word: cmd (queue, commit, rewind, graduate),
//   conn_id, op_id and csn_token. rsp_ch returns exactly one result word per
//   command: found, max_valid, max_csn, queue_full. Both are valid/ready.
//   Entries live in a single-port-read RAM of QUEUE_DEPTH x 129 bits; the
//   sequencer walks it one address per cycle.
// Steps per command:
//   queue     : append write of the new entry
//   rewind    : match pass, then one write on a hit
//   graduate  : match pass, then the shift pass over the tail on a hit
//   commit    : match pass, write on a hit, then committed-prefix pass
//   One item is in work at a time and cmd_ch.ready is low until idle again.
// The result sits in an output register, so the next command is taken
// while rsp_ch stalls; that command then holds its result until the
// register frees up.
// Reset: arst_n clears the entry count and the sequencer; the queue is
// empty right after reset, and RAM contents need no clearing.
module pending_commit_order_queue_top #(
	parameter int QUEUE_DEPTH = pcoq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pcoq_cmd_if.sink  cmd_ch,
	pcoq_rsp_if.source rsp_ch
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	pcoq_pkg::entry_t       ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	pcoq_pkg::entry_t       ram_rdata;

	logic                   res_valid;
	logic                   res_ready;
	pcoq_pkg::res_t         res;

	logic                   rsp_valid_q;
	pcoq_pkg::res_t         rsp_q;

	pcoq_ram #(
		.WIDTH ($bits(pcoq_pkg::entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pcoq_seq #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: free when empty or being drained this cycle
	assign res_ready = !rsp_valid_q || rsp_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_ch.valid      = rsp_valid_q;
	assign rsp_ch.found      = rsp_q.found;
	assign rsp_ch.max_valid  = rsp_q.max_valid;
	assign rsp_ch.max_csn    = rsp_q.max_csn;
	assign rsp_ch.queue_full = rsp_q.queue_full;

endmodule
